// ===== design/sem_pkg.sv =====
`default_nettype none
package sem_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned PIX_W         = 24;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned WREG_W        = 11;
  localparam int unsigned HREG_W        = 13;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned GRAD_W        = 11;
  localparam int unsigned SUMSQ_W       = 21;
  localparam int unsigned SAT_LIMIT     = 65280;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pixel_t;

  // masked 3x3 neighborhood, [row][col], red 23:16, green 15:8, blue 7:0
  typedef struct packed {
    pixel_t [2:0][2:0] pix;
    logic              frame_end;
  } desc_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SQUARE,
    B_ROOT,
    B_OUT
  } back_state_e;

endpackage
`default_nettype wire

// ===== design/sobel_edge_magnitude_rgb.sv =====
`default_nettype none
// channel   | handshake                | payload
// pixel in  | push_i / full_o          | mode_i red_i green_i blue_i
// result    | empty_o / pop_i          | edge_red_o edge_green_o edge_blue_o frame_end_o
// config    | cfg_valid_i / cfg_ready_o| cfg_index_i cfg_data_i
//
// Front reads the line stores on accept, then writes back and shifts the window; it takes no new item meanwhile.
// Back steps through gradients, squares, an 8-step root search and output for each result.
// Items that give no result pass through the front only; a 2-entry queue sits between.
// Reset clears counters, window and queue; line stores hold no reset.
// A result waits in the output register until popped; the back stalls behind it.
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic                           mode_i,
  input  wire logic [sem_pkg::CH_W-1:0]       red_i,
  input  wire logic [sem_pkg::CH_W-1:0]       green_i,
  input  wire logic [sem_pkg::CH_W-1:0]       blue_i,
  output logic                                empty_o,
  input  wire logic                           pop_i,
  output logic [sem_pkg::CH_W-1:0]            edge_red_o,
  output logic [sem_pkg::CH_W-1:0]            edge_green_o,
  output logic [sem_pkg::CH_W-1:0]            edge_blue_o,
  output logic                                frame_end_o
);
  import sem_pkg::*;

  desc_t push_data, head_data;
  logic  q_push, q_full, q_pop, q_empty;

  assign cfg_ready_o = 1'b1;

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .mode_i      (mode_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (push_data)
  );

  sem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (head_data)
  );

  sem_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (head_data),
    .q_pop_o      (q_pop),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .edge_red_o   (edge_red_o),
    .edge_green_o (edge_green_o),
    .edge_blue_o  (edge_blue_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
`default_nettype wire

// ===== design/sem_front.sv =====
`default_nettype none
module sem_front #(
  parameter int unsigned MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic                           mode_i,
  input  wire logic [sem_pkg::CH_W-1:0]       red_i,
  input  wire logic [sem_pkg::CH_W-1:0]       green_i,
  input  wire logic [sem_pkg::CH_W-1:0]       blue_i,
  input  wire logic                           q_full_i,
  output logic                                q_push_o,
  output sem_pkg::desc_t                      q_data_o
);
  import sem_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = HREG_W + 1;

  logic [WREG_W-1:0] wreg_q;
  logic [HREG_W-1:0] hreg_q;
  logic [CW-1:0]     col_q;
  logic [HREG_W-1:0] row_q;
  logic              busy_q;

  pixel_t line_upper [MAX_WIDTH];
  pixel_t line_middle [MAX_WIDTH];
  pixel_t up_rd_q, mid_rd_q, px_q;
  logic [CW-1:0] wcol_q;
  logic [2:0]    use_row_q, use_col_q;
  logic          emit_q, end_q;
  pixel_t [2:0][2:0] win_q;
  pixel_t [2:0][2:0] win_d;

  logic [EW-1:0] w;
  logic [RW-1:0] h, hp1, r14, r0;
  logic [CW-1:0] c0;
  logic          restart, accept, emit, fend;
  logic [RW-1:0] qr;
  logic [EW-1:0] qc, cnext;
  logic [2:0]    use_row, use_col;

  always_comb begin
    if (wreg_q == '0) begin
      w = EW'(1);
    end else if (32'(wreg_q) > 32'(MAX_WIDTH)) begin
      w = EW'(MAX_WIDTH);
    end else begin
      w = EW'(wreg_q);
    end
    if (hreg_q == '0) begin
      h = RW'(1);
    end else if (32'(hreg_q) > 32'(HEIGHT_LIMIT)) begin
      h = RW'(HEIGHT_LIMIT);
    end else begin
      h = RW'(hreg_q);
    end
    hp1 = h + RW'(1);
    r14 = RW'(row_q);
    restart = (r14 > hp1) || ((r14 == hp1) && (col_q != '0));
    r0 = restart ? '0 : r14;
    c0 = restart ? '0 : col_q;
    emit = (r0 >= RW'(2)) || ((r0 == RW'(1)) && (c0 != '0));
    fend = (c0 == '0) && (r0 == hp1);
    qr = (c0 == '0) ? r0 - RW'(2) : r0 - RW'(1);
    qc = (c0 == '0) ? w - EW'(1) : EW'(c0) - EW'(1);
    use_row = {(qr + RW'(1)) < h, 1'b1, qr != '0};
    use_col = {(qc + EW'(1)) < w, 1'b1, qc != '0};
    cnext = EW'(c0) + EW'(1);
    accept = push_i && !full_o;
  end

  assign full_o = busy_q || q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q <= WREG_W'(DEF_MAX_WIDTH);
      hreg_q <= HREG_W'(1);
      col_q  <= '0;
      row_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == CFG_IMAGE_WIDTH)) begin
        wreg_q <= cfg_data_i[WREG_W-1:0];
      end
      if (cfg_valid_i && (cfg_index_i == CFG_IMAGE_HEIGHT)) begin
        hreg_q <= cfg_data_i[HREG_W-1:0];
      end
      busy_q <= accept;
      if (accept) begin
        if (fend) begin
          col_q <= '0;
          row_q <= '0;
        end else if (cnext >= w) begin
          col_q <= '0;
          row_q <= HREG_W'(r0 + RW'(1));
        end else begin
          col_q <= cnext[CW-1:0];
          row_q <= HREG_W'(r0);
        end
      end
    end
  end

  // line stores: read on accept, written back the cycle after
  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q  <= line_upper[c0];
      mid_rd_q <= line_middle[c0];
    end
    if (busy_q) begin
      line_upper[wcol_q]  <= mid_rd_q;
      line_middle[wcol_q] <= px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q      <= mode_i ? '0 : {red_i, green_i, blue_i};
      wcol_q    <= c0;
      use_row_q <= use_row;
      use_col_q <= use_col;
      emit_q    <= emit;
      end_q     <= fend;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = up_rd_q;
    win_d[1][2] = mid_rd_q;
    win_d[2][2] = px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (busy_q) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        q_data_o.pix[i][j] = (use_row_q[i] && use_col_q[j]) ? win_d[i][j] : '0;
      end
    end
    q_data_o.frame_end = end_q;
  end

  assign q_push_o = busy_q && emit_q;

endmodule
`default_nettype wire

// ===== design/sem_queue.sv =====
`default_nettype none
module sem_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  sem_pkg::desc_t      data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output sem_pkg::desc_t      data_o
);
  import sem_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  desc_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [NW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == NW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/sem_back.sv =====
`default_nettype none
module sem_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_empty_i,
  input  sem_pkg::desc_t                q_data_i,
  output logic                          q_pop_o,
  output logic                          empty_o,
  input  wire logic                     pop_i,
  output logic [sem_pkg::CH_W-1:0]      edge_red_o,
  output logic [sem_pkg::CH_W-1:0]      edge_green_o,
  output logic [sem_pkg::CH_W-1:0]      edge_blue_o,
  output logic                          frame_end_o
);
  import sem_pkg::*;

  back_state_e state_q, state_d;

  logic signed [GRAD_W-1:0] gx_q [3];
  logic signed [GRAD_W-1:0] gy_q [3];
  logic signed [GRAD_W-1:0] gx_d [3];
  logic signed [GRAD_W-1:0] gy_d [3];
  logic [15:0]       s_q [3];
  logic              sat_q [3];
  logic [CH_W-1:0]   root_q [3];
  logic [CH_W-1:0]   root_d [3];
  logic [CH_W-1:0]   mag [3];
  logic [SUMSQ_W-1:0] sumsq [3];
  logic [2:0]        bit_q;
  logic              fend_q;
  logic              out_valid_q;
  logic [CH_W-1:0]   out_q [3];
  logic              out_end_q;
  logic              load_out;

  always_comb begin
    logic [CH_W-1:0] v [3][3];
    logic [GRAD_W-1:0] xp, xn, yp, yn;
    logic signed [2*GRAD_W-1:0] pxx, pyy;
    logic [CH_W-1:0] trial;
    logic [15:0] tsq;
    logic [16:0] rsq;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          v[i][j] = q_data_i.pix[i][j][CH_W*(2-ch) +: CH_W];
        end
      end
      xp = GRAD_W'(v[0][2]) + (GRAD_W'(v[1][2]) << 1) + GRAD_W'(v[2][2]);
      xn = GRAD_W'(v[0][0]) + (GRAD_W'(v[1][0]) << 1) + GRAD_W'(v[2][0]);
      yp = GRAD_W'(v[2][0]) + (GRAD_W'(v[2][1]) << 1) + GRAD_W'(v[2][2]);
      yn = GRAD_W'(v[0][0]) + (GRAD_W'(v[0][1]) << 1) + GRAD_W'(v[0][2]);
      gx_d[ch] = $signed(xp) - $signed(xn);
      gy_d[ch] = $signed(yp) - $signed(yn);

      pxx = gx_q[ch] * gx_q[ch];
      pyy = gy_q[ch] * gy_q[ch];
      sumsq[ch] = SUMSQ_W'(pxx[19:0]) + SUMSQ_W'(pyy[19:0]);

      // one root bit per cycle, MSB first
      trial = root_q[ch] | (CH_W'(1) << bit_q);
      tsq = {8'd0, trial} * {8'd0, trial};
      root_d[ch] = (tsq <= s_q[ch]) ? trial : root_q[ch];

      rsq = {9'd0, root_q[ch]} * {9'd0, root_q[ch]} + 17'(root_q[ch]);
      if (sat_q[ch]) begin
        mag[ch] = 8'd255;
      end else if (17'(s_q[ch]) > rsq) begin
        mag[ch] = root_q[ch] + CH_W'(1);
      end else begin
        mag[ch] = root_q[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = B_SQUARE;
        end
      end
      B_SQUARE: state_d = B_ROOT;
      B_ROOT: begin
        if (bit_q == '0) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_q || pop_i) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        for (int ch = 0; ch < 3; ch++) begin
          gx_q[ch] <= gx_d[ch];
          gy_q[ch] <= gy_d[ch];
        end
        fend_q <= q_data_i.frame_end;
      end
      B_SQUARE: begin
        for (int ch = 0; ch < 3; ch++) begin
          s_q[ch]    <= sumsq[ch][15:0];
          sat_q[ch]  <= sumsq[ch] > SUMSQ_W'(SAT_LIMIT);
          root_q[ch] <= '0;
        end
        bit_q <= 3'd7;
      end
      B_ROOT: begin
        for (int ch = 0; ch < 3; ch++) begin
          root_q[ch] <= root_d[ch];
        end
        bit_q <= bit_q - 3'd1;
      end
      default: ;
    endcase
    if (load_out) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_q[ch] <= mag[ch];
      end
      out_end_q <= fend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign empty_o      = !out_valid_q;
  assign edge_red_o   = out_q[0];
  assign edge_green_o = out_q[1];
  assign edge_blue_o  = out_q[2];
  assign frame_end_o  = out_end_q;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || pop_i))
    else $error("result overwritten");

  // red root search leaves a root whose square does not exceed the sum
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_OUT) |-> ({8'd0, root_q[0]} * {8'd0, root_q[0]} <= s_q[0]))
    else $error("root too large");

  // queue is only drained from idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == B_SQUARE))
    else $error("pop outside idle");

endmodule
`default_nettype wire
